@@ design/tcrr_pkg.sv @@
`timescale 1ns / 1ps

package tcrr_pkg;

    // Fixed field widths
    localparam int MASK_W     = 16;
    localparam int POS_W      = 4;
    localparam int SIZE_W     = 3;
    localparam int OP_W       = 2;
    localparam int TIME_W     = 32;
    localparam int CHARS_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Opcodes (code 3 is unused and ignored)
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] WINDOW_RST = 16'd500;
    localparam logic [15:0] IDLE_RST   = 16'd2000;
    localparam logic [7:0]  LIMIT_RST  = 8'd64;

    typedef enum logic [2:0] {
        EV_SHOW   = 3'd0,
        EV_HIDE   = 3'd1,
        EV_COMMIT = 3'd2,
        EV_DROP   = 3'd3,
        EV_DONE   = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WAIT   = 3'd1,
        MODE_TRACK  = 3'd2,
        MODE_WINDOW = 3'd3,
        MODE_DONE   = 3'd4
    } t_mode;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [MASK_W-1:0] touch_mask;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        t_event            event_kind;
        logic [POS_W-1:0]  position;
        logic [MASK_W-1:0] chord_mask;
        logic [SIZE_W-1:0] chord_size;
        logic              last;
    } t_out_word;

endpackage

@@ design/touch_chord_release_recorder.sv @@
`timescale 1ns / 1ps

// Touch chord release recorder. Input words are start, stop or a touch sample
// (mask plus millisecond timestamp). Each word is processed in the cycle it is
// accepted: state is updated at once and its results (show events in
// ascending position, hide events in ascending position, then at most one
// chord committed/dropped event and at most one recording complete event) are
// loaded into a result buffer. While the output register is free or being
// read, the buffer hands one result word per cycle to it; the last result of
// a word carries last = 1. A word that causes no result leaves the buffer
// empty, so such words are taken every cycle. A word with N results holds
// the input off until the buffer has handed all N on, which output stalls
// delay: the next word is accepted once the buffer is empty, which can be
// while the final result still sits in the output register. Config writes
// take effect on the next cycle and should only be issued while idle.
module touch_chord_release_recorder #(
    parameter int POSITIONS = 16,
    parameter int MAX_CHORD = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [tcrr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tcrr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tcrr_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tcrr_pkg::t_out_word                o_out_word
);
    import tcrr_pkg::*;

    localparam int CntW = $clog2(MAX_CHORD + 1);
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CHORD);
    // Mask bits at or above POSITIONS are ignored
    localparam logic [MASK_W-1:0] PosMask =
        (POSITIONS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << POSITIONS) - 64'd1);

    // Configuration
    logic [15:0]        r_window_ms;
    logic [15:0]        r_idle_ms;
    logic [7:0]         r_seq_limit;

    // Recorder state
    t_mode              r_mode, n_mode;
    logic [MASK_W-1:0]  r_touched, n_touched;
    logic [MASK_W-1:0]  r_shown, n_shown;
    logic [MASK_W-1:0]  r_pend, n_pend;
    logic [CntW-1:0]    r_cnt, n_cnt;
    logic [TIME_W-1:0]  r_wstart, n_wstart;
    logic [TIME_W-1:0]  r_lrel, n_lrel;
    logic [CHARS_W-1:0] r_chars, n_chars;

    // Result buffer: pending results of the last accepted word
    logic [MASK_W-1:0]  r_b_show, n_b_show;
    logic [MASK_W-1:0]  r_b_hide, n_b_hide;
    logic               r_b_chord, n_b_chord;
    logic               r_b_drop, n_b_drop;
    logic [MASK_W-1:0]  r_b_cmask, n_b_cmask;
    logic [SIZE_W-1:0]  r_b_csize, n_b_csize;
    logic               r_b_done, n_b_done;

    // Buffer after popping the head result
    logic [MASK_W-1:0]  p_show, p_hide;
    logic               p_chord, p_done;

    // Output register
    logic               r_out_valid;
    t_out_word          r_out_word;
    t_out_word          head_word;

    // Working signals
    logic               accept, pop, buf_busy, active;
    logic               do_commit, do_finish;
    logic [MASK_W-1:0]  sample, rise, fall, elig, add;
    logic [CntW-1:0]    room;
    logic [9:0]         fit_sum;
    logic [TIME_W-1:0]  now;

    function automatic logic [POS_W-1:0] low_index(input logic [MASK_W-1:0] m);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = POS_W'(i);
            end
        end
        return idx;
    endfunction

    assign buf_busy   = (|r_b_show) | (|r_b_hide) | r_b_chord | r_b_done;
    assign o_in_ready = !buf_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign pop        = buf_busy && (!r_out_valid || i_out_ready);
    assign now        = i_in_word.now_ms;

    // Releases join the chord in ascending order until it is full: a released
    // position is taken when fewer eligible ones below it than free slots.
    always_comb begin
        sample = i_in_word.touch_mask & PosMask;
        rise   = sample & ~r_touched;
        fall   = ~sample & r_touched & r_shown;
        elig   = fall & ~r_pend;
        room   = MaxCnt - r_cnt;
        for (int i = 0; i < MASK_W; i++) begin
            add[i] = elig[i] &&
                ($countones(elig & ((MASK_W'(1) << i) - MASK_W'(1))) < int'(room));
        end
    end

    // Next state and result set for the word at the input
    always_comb begin
        n_mode    = r_mode;
        n_touched = r_touched;
        n_shown   = r_shown;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        n_wstart  = r_wstart;
        n_lrel    = r_lrel;
        n_chars   = r_chars;
        n_b_show  = '0;
        n_b_hide  = '0;
        n_b_chord = 1'b0;
        n_b_drop  = 1'b0;
        n_b_cmask = '0;
        n_b_csize = '0;
        n_b_done  = 1'b0;
        do_commit = 1'b0;
        do_finish = 1'b0;
        fit_sum   = '0;
        active    = (r_mode != MODE_IDLE) && (r_mode != MODE_DONE);

        case (i_in_word.opcode)
            OP_START: begin
                n_mode    = MODE_WAIT;
                n_touched = '0;
                n_shown   = '0;
                n_pend    = '0;
                n_cnt     = '0;
                n_wstart  = '0;
                n_lrel    = '0;
                n_chars   = '0;
            end
            OP_STOP: begin
                if (active) begin
                    do_commit = 1'b1;
                    do_finish = 1'b1;
                end
            end
            OP_TICK: begin
                if (active) begin
                    n_touched = sample;
                    n_b_show  = rise & ~r_shown;
                    n_b_hide  = fall;
                    n_shown   = (r_shown | rise) & ~fall;
                    if ((|rise) && r_mode == MODE_WAIT) begin
                        n_mode = MODE_TRACK;
                    end
                    n_pend = r_pend | add;
                    n_cnt  = r_cnt + CntW'($countones(add));
                    if ((|add) && n_mode != MODE_WINDOW) begin
                        n_wstart = now;
                        n_mode   = MODE_WINDOW;
                    end
                    if (|fall) begin
                        n_lrel = now;
                    end
                    do_commit = (n_mode == MODE_WINDOW) &&
                                ((now - n_wstart) >= TIME_W'(r_window_ms));
                end
            end
            default: begin
            end
        endcase

        // Chord of k positions costs 2k-1 chars plus a comma after the first
        if (do_commit) begin
            if (n_cnt != '0) begin
                fit_sum   = 10'(n_chars) + (10'(n_cnt) << 1) + 10'(n_chars != '0);
                n_b_chord = 1'b1;
                n_b_cmask = n_pend;
                n_b_csize = SIZE_W'(n_cnt);
                if (fit_sum >= 10'(r_seq_limit)) begin
                    n_b_drop = 1'b1;
                end else begin
                    n_chars = CHARS_W'(fit_sum - 10'd1);
                end
            end
            n_pend = '0;
            n_cnt  = '0;
            n_mode = MODE_TRACK;
        end

        // Idle timeout after the last release
        if (i_in_word.opcode == OP_TICK && active &&
            (n_mode == MODE_TRACK || n_mode == MODE_WAIT) &&
            n_chars != '0 && sample == '0 &&
            ((now - n_lrel) >= TIME_W'(r_idle_ms))) begin
            do_finish = 1'b1;
        end

        if (do_finish) begin
            n_mode   = MODE_DONE;
            n_b_done = 1'b1;
        end
    end

    // Head of the result buffer
    always_comb begin
        p_show                = r_b_show;
        p_hide                = r_b_hide;
        p_chord               = r_b_chord;
        p_done                = r_b_done;
        head_word.event_kind  = EV_DONE;
        head_word.position    = '0;
        head_word.chord_mask  = '0;
        head_word.chord_size  = '0;
        if (|r_b_show) begin
            head_word.event_kind = EV_SHOW;
            head_word.position   = low_index(r_b_show);
            p_show               = r_b_show & (r_b_show - MASK_W'(1));
        end else if (|r_b_hide) begin
            head_word.event_kind = EV_HIDE;
            head_word.position   = low_index(r_b_hide);
            p_hide               = r_b_hide & (r_b_hide - MASK_W'(1));
        end else if (r_b_chord) begin
            head_word.event_kind = r_b_drop ? EV_DROP : EV_COMMIT;
            head_word.chord_mask = r_b_cmask;
            head_word.chord_size = r_b_csize;
            p_chord              = 1'b0;
        end else begin
            p_done               = 1'b0;
        end
        head_word.last = !((|p_show) || (|p_hide) || p_chord || p_done);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ms <= WINDOW_RST;
            r_idle_ms   <= IDLE_RST;
            r_seq_limit <= LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WINDOW: r_window_ms <= i_cfg_wdata;
                CFG_IDLE:   r_idle_ms   <= i_cfg_wdata;
                CFG_LIMIT:  r_seq_limit <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Recorder state and result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_touched <= '0;
            r_shown   <= '0;
            r_pend    <= '0;
            r_cnt     <= '0;
            r_wstart  <= '0;
            r_lrel    <= '0;
            r_chars   <= '0;
            r_b_show  <= '0;
            r_b_hide  <= '0;
            r_b_chord <= 1'b0;
            r_b_drop  <= 1'b0;
            r_b_cmask <= '0;
            r_b_csize <= '0;
            r_b_done  <= 1'b0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_touched <= n_touched;
            r_shown   <= n_shown;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            r_wstart  <= n_wstart;
            r_lrel    <= n_lrel;
            r_chars   <= n_chars;
            r_b_show  <= n_b_show;
            r_b_hide  <= n_b_hide;
            r_b_chord <= n_b_chord;
            r_b_drop  <= n_b_drop;
            r_b_cmask <= n_b_cmask;
            r_b_csize <= n_b_csize;
            r_b_done  <= n_b_done;
        end else if (pop) begin
            r_b_show  <= p_show;
            r_b_hide  <= p_hide;
            r_b_chord <= p_chord;
            r_b_done  <= p_done;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_word <= head_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ design/tcrr_checker.sv @@
`timescale 1ns / 1ps

module tcrr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input tcrr_pkg::t_out_word             o_out_word
);
    import tcrr_pkg::*;

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // Show and hide name a position only
    a_pos_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.event_kind == EV_SHOW ||
                        o_out_word.event_kind == EV_HIDE)
        |-> o_out_word.chord_mask == '0 && o_out_word.chord_size == '0)
        else $error("show/hide word carries chord data");

    // Chord words carry a nonempty mask and no position
    a_chord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.event_kind == EV_COMMIT ||
                        o_out_word.event_kind == EV_DROP)
        |-> o_out_word.chord_mask != '0 && o_out_word.position == '0)
        else $error("chord word malformed");

    // Recording complete is always the final result of its input word
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_kind == EV_DONE |-> o_out_word.last)
        else $error("complete event not last");

endmodule

bind touch_chord_release_recorder tcrr_checker u_tcrr_checker (.*);
